// ===== rtl/blpg_pkg.sv =====
// Shared types and constants of the Bresenham line pixel generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package blpg_pkg;

  localparam int unsigned COORD_BITS = 8;
  localparam int unsigned COLOR_BITS = 8;
  localparam int unsigned STRIDE_BITS = 8;
  localparam int unsigned ADDR_BITS = 16;

  localparam logic [STRIDE_BITS-1:0] ROW_STRIDE_RESET = 8'd160;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  typedef logic [1:0] step_t;
  localparam step_t STEP_NONE = 2'd0;
  localparam step_t STEP_POS  = 2'd1;
  localparam step_t STEP_NEG  = 2'd3;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [COLOR_BITS-1:0] line_color;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    logic [ADDR_BITS-1:0]  pixel_address;
    logic [COLOR_BITS-1:0] pixel_color;
    logic                  pixel_valid;
    logic                  line_done;
  } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/blpg_in_stage.sv =====
// Input register of the line generator: holds one accepted input transfer.
// Depends on blpg_pkg for the input item type.
`default_nettype none

module blpg_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire blpg_pkg::in_item_t in_data,
  output logic                   item_valid,
  output blpg_pkg::in_item_t     item_data,
  input  wire logic              item_pop
);
  import blpg_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  assign in_ready   = !valid_r || item_pop;
  assign item_valid = valid_r;
  assign item_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpg_engine.sv =====
// Line state registers, row stride register and the per-item pixel logic.
// Depends on blpg_pkg for item types, step codes and widths.
`default_nettype none

module blpg_engine (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [blpg_pkg::STRIDE_BITS-1:0]   cfg_wdata,
  input  wire logic                               item_fire,
  input  wire blpg_pkg::in_item_t                 item_data,
  output blpg_pkg::out_item_t                     result
);
  import blpg_pkg::*;

  logic [STRIDE_BITS-1:0] row_stride_r;
  logic [COORD_BITS-1:0]  cursor_x_r, cursor_x_nxt;
  logic [COORD_BITS-1:0]  cursor_y_r, cursor_y_nxt;
  logic [COORD_BITS-1:0]  error_term_r, error_term_nxt;
  logic [COORD_BITS-1:0]  major_r, major_nxt;
  logic [COORD_BITS-1:0]  minor_r, minor_nxt;
  step_t                  diag_x_r, diag_x_nxt;
  step_t                  diag_y_r, diag_y_nxt;
  step_t                  str_x_r, str_x_nxt;
  step_t                  str_y_r, str_y_nxt;
  logic [COORD_BITS-1:0]  pixels_left_r, pixels_left_nxt;
  logic [COLOR_BITS-1:0]  held_color_r, held_color_nxt;
  logic                   line_active_r, line_active_nxt;

  logic                   x_fwd, y_fwd;
  logic [COORD_BITS-1:0]  adx, ady;
  logic [COORD_BITS-1:0]  src_x, src_y, src_err, src_major, src_minor;
  step_t                  src_dx, src_dy, src_sx, src_sy;
  logic                   take_diag;
  logic [COORD_BITS-1:0]  emit_x, emit_y;
  logic [ADDR_BITS-1:0]   stride_prod;

  function automatic logic [COORD_BITS-1:0] move_coord(
    input logic [COORD_BITS-1:0] c,
    input step_t                 s
  );
    logic [COORD_BITS-1:0] r;
    case (s)
      STEP_POS: r = c + COORD_BITS'(1);
      STEP_NEG: r = c - COORD_BITS'(1);
      default:  r = c;
    endcase
    return r;
  endfunction

  assign x_fwd = item_data.start_x < item_data.end_x;
  assign y_fwd = item_data.start_y < item_data.end_y;
  assign adx   = x_fwd ? item_data.end_x - item_data.start_x
                       : item_data.start_x - item_data.end_x;
  assign ady   = y_fwd ? item_data.end_y - item_data.start_y
                       : item_data.start_y - item_data.end_y;

  always_comb begin
    cursor_x_nxt    = cursor_x_r;
    cursor_y_nxt    = cursor_y_r;
    error_term_nxt  = error_term_r;
    major_nxt       = major_r;
    minor_nxt       = minor_r;
    diag_x_nxt      = diag_x_r;
    diag_y_nxt      = diag_y_r;
    str_x_nxt       = str_x_r;
    str_y_nxt       = str_y_r;
    pixels_left_nxt = pixels_left_r;
    held_color_nxt  = held_color_r;
    line_active_nxt = line_active_r;

    src_x     = cursor_x_r;
    src_y     = cursor_y_r;
    src_err   = error_term_r;
    src_major = major_r;
    src_minor = minor_r;
    src_dx    = diag_x_r;
    src_dy    = diag_y_r;
    src_sx    = str_x_r;
    src_sy    = str_y_r;

    result    = '0;
    emit_x    = cursor_x_r;
    emit_y    = cursor_y_r;

    if (item_data.kind == KIND_START) begin
      src_x  = item_data.start_x;
      src_y  = item_data.start_y;
      src_dx = x_fwd ? STEP_POS : STEP_NEG;
      src_dy = y_fwd ? STEP_POS : STEP_NEG;
      if (adx < ady) begin
        src_major = ady;
        src_minor = adx;
        src_sx    = STEP_NONE;
        src_sy    = src_dy;
      end else begin
        src_major = adx;
        src_minor = ady;
        src_sx    = src_dx;
        src_sy    = STEP_NONE;
      end
      src_err = src_major >> 1;

      emit_x               = item_data.start_x;
      emit_y               = item_data.start_y;
      result.pixel_color   = item_data.line_color;
      result.pixel_valid   = 1'b1;
      result.line_done     = (src_major == '0);
      held_color_nxt       = item_data.line_color;
      pixels_left_nxt      = src_major;
      line_active_nxt      = (src_major != '0);
    end else if (!line_active_r || pixels_left_r == '0) begin
      line_active_nxt = 1'b0;
    end else begin
      pixels_left_nxt    = pixels_left_r - COORD_BITS'(1);
      result.pixel_color = held_color_r;
      result.pixel_valid = 1'b1;
      result.line_done   = (pixels_left_nxt == '0);
      line_active_nxt    = (pixels_left_nxt != '0);
    end

    if (result.pixel_valid) begin
      result.pixel_x = emit_x;
      result.pixel_y = emit_y;
      result.pixel_address = stride_prod + ADDR_BITS'(emit_x);
      major_nxt  = src_major;
      minor_nxt  = src_minor;
      diag_x_nxt = src_dx;
      diag_y_nxt = src_dy;
      str_x_nxt  = src_sx;
      str_y_nxt  = src_sy;
      if (take_diag) begin
        error_term_nxt = src_err + src_minor - src_major;
        cursor_x_nxt   = move_coord(src_x, src_dx);
        cursor_y_nxt   = move_coord(src_y, src_dy);
      end else begin
        error_term_nxt = src_err + src_minor;
        cursor_x_nxt   = move_coord(src_x, src_sx);
        cursor_y_nxt   = move_coord(src_y, src_sy);
      end
    end
  end

  assign take_diag   = src_err >= (src_major - src_minor);
  assign stride_prod = ADDR_BITS'(row_stride_r) * ADDR_BITS'(emit_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_stride_r <= ROW_STRIDE_RESET;
    end else if (cfg_we) begin
      row_stride_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r    <= '0;
      cursor_y_r    <= '0;
      error_term_r  <= '0;
      major_r       <= '0;
      minor_r       <= '0;
      diag_x_r      <= STEP_NONE;
      diag_y_r      <= STEP_NONE;
      str_x_r       <= STEP_NONE;
      str_y_r       <= STEP_NONE;
      pixels_left_r <= '0;
      held_color_r  <= '0;
      line_active_r <= 1'b0;
    end else if (item_fire) begin
      cursor_x_r    <= cursor_x_nxt;
      cursor_y_r    <= cursor_y_nxt;
      error_term_r  <= error_term_nxt;
      major_r       <= major_nxt;
      minor_r       <= minor_nxt;
      diag_x_r      <= diag_x_nxt;
      diag_y_r      <= diag_y_nxt;
      str_x_r       <= str_x_nxt;
      str_y_r       <= str_y_nxt;
      pixels_left_r <= pixels_left_nxt;
      held_color_r  <= held_color_nxt;
      line_active_r <= line_active_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/blpg_out_stage.sv =====
// Result register of the line generator: holds one result until transfer.
// Depends on blpg_pkg for the result item type.
`default_nettype none

module blpg_out_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire blpg_pkg::out_item_t push_data,
  output logic                   can_push,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output blpg_pkg::out_item_t    out_data
);
  import blpg_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign can_push  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (can_push) begin
      valid_nxt = push;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && can_push) begin
      data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bresenham_line_pixel_generator_top.sv =====
// Bresenham line pixel generator: a start item loads a line and yields its first
// pixel; a step item yields the next pixel of an active line with its frame buffer
// address (row_stride * y + x), else a result with pixel_valid low. The block takes
// one item per clock while out_ready does not stall the output register; an item is
// held in the input register and its result registered in the output register. The
// line state registers are updated once per item. row_stride is written through
// cfg_we/cfg_wdata while idle; the user must keep to this, the block does not enforce it.
// Depends on blpg_pkg, blpg_in_stage, blpg_engine and blpg_out_stage.
`default_nettype none

module bresenham_line_pixel_generator_top (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire blpg_pkg::in_item_t                 in_data,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output blpg_pkg::out_item_t                     out_data,
  input  wire logic                               cfg_we,
  input  wire logic [blpg_pkg::STRIDE_BITS-1:0]   cfg_wdata
);
  import blpg_pkg::*;

  logic      item_valid;
  in_item_t  item_data;
  logic      can_push;
  logic      item_fire;
  out_item_t result;

  assign item_fire = item_valid && can_push;

  blpg_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_pop   (item_fire)
  );

  blpg_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_fire (item_fire),
    .item_data (item_data),
    .result    (result)
  );

  blpg_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_valid),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for bresenham_line_pixel_generator_top: drives start and step
// items, predicts every pixel from its own line-drawing state and compares each transfer.
// Depends on blpg_pkg and the RTL top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import blpg_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [STRIDE_BITS-1:0] cfg_wdata = '0;

  in_item_t pending_items[$];
  out_item_t expected_pixels[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit send_hold = 1'b0;
  bit rx_hold = 1'b0;
  bit in_taken = 1'b0;

  // line state of the predictor
  logic [STRIDE_BITS-1:0] stride = ROW_STRIDE_RESET;
  logic [COORD_BITS-1:0] cur_x = '0, cur_y = '0;
  logic [COORD_BITS-1:0] err = '0, major = '0, minor = '0;
  step_t dstep_x = STEP_NONE, dstep_y = STEP_NONE;
  step_t sstep_x = STEP_NONE, sstep_y = STEP_NONE;
  logic [COORD_BITS:0] left = '0;
  logic [COLOR_BITS-1:0] color = '0;
  bit drawing = 1'b0;

  bresenham_line_pixel_generator_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  function automatic logic [COORD_BITS-1:0] move(logic [COORD_BITS-1:0] c, step_t s);
    if (s == STEP_POS) return c + 1'b1;
    if (s == STEP_NEG) return c - 1'b1;
    return c;
  endfunction

  function automatic void step_cursor();
    if (err >= major - minor) begin
      err = err + minor - major;
      cur_x = move(cur_x, dstep_x);
      cur_y = move(cur_y, dstep_y);
    end else begin
      err = err + minor;
      cur_x = move(cur_x, sstep_x);
      cur_y = move(cur_y, sstep_y);
    end
  endfunction

  function automatic out_item_t pixel_at(bit last);
    out_item_t px;
    px.pixel_x = cur_x;
    px.pixel_y = cur_y;
    px.pixel_address = {8'd0, stride} * {8'd0, cur_y} + {8'd0, cur_x};
    px.pixel_color = color;
    px.pixel_valid = 1'b1;
    px.line_done = last;
    return px;
  endfunction

  function automatic out_item_t next_pixel(in_item_t it);
    out_item_t px;
    logic [COORD_BITS-1:0] adx, ady;
    px = '0;
    if (it.kind == KIND_START) begin
      cur_x = it.start_x;
      cur_y = it.start_y;
      color = it.line_color;
      dstep_x = (it.start_x < it.end_x) ? STEP_POS : STEP_NEG;
      dstep_y = (it.start_y < it.end_y) ? STEP_POS : STEP_NEG;
      adx = (it.start_x < it.end_x) ? it.end_x - it.start_x : it.start_x - it.end_x;
      ady = (it.start_y < it.end_y) ? it.end_y - it.start_y : it.start_y - it.end_y;
      if (adx < ady) begin
        major = ady;
        minor = adx;
        sstep_x = STEP_NONE;
        sstep_y = dstep_y;
      end else begin
        major = adx;
        minor = ady;
        sstep_x = dstep_x;
        sstep_y = STEP_NONE;
      end
      err = major >> 1;
      left = {1'b0, major};
      px = pixel_at(left == 0);
      drawing = (left != 0);
      step_cursor();
    end else if (drawing && left != 0) begin
      left = left - 1'b1;
      px = pixel_at(left == 0);
      if (left == 0) drawing = 1'b0;
      step_cursor();
    end else begin
      drawing = 1'b0;
    end
    return px;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("[%0t] %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin
    if (rst_n && cfg_we) stride = cfg_wdata;
    if (rst_n && in_valid && in_ready) begin
      expected_pixels.push_back(next_pixel(in_data));
      in_taken = 1'b1;
    end
  end

  always @(posedge clk) begin : monitor
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected transfer", out_data.pixel_address, 16'd0);
      end else begin
        want = expected_pixels.pop_front();
        check_field("pixel_x", 16'(out_data.pixel_x), 16'(want.pixel_x));
        check_field("pixel_y", 16'(out_data.pixel_y), 16'(want.pixel_y));
        check_field("pixel_address", out_data.pixel_address, want.pixel_address);
        check_field("pixel_color", 16'(out_data.pixel_color), 16'(want.pixel_color));
        check_field("pixel_valid", 16'(out_data.pixel_valid), 16'(want.pixel_valid));
        check_field("line_done", 16'(out_data.line_done), 16'(want.line_done));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_items.size() > 0 && !send_hold && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (rx_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic in_item_t start_item(int x0, int y0, int x1, int y1, int c);
    in_item_t it;
    it.kind = KIND_START;
    it.start_x = COORD_BITS'(x0);
    it.start_y = COORD_BITS'(y0);
    it.end_x = COORD_BITS'(x1);
    it.end_y = COORD_BITS'(y1);
    it.line_color = COLOR_BITS'(c);
    return it;
  endfunction

  function automatic in_item_t step_item();
    in_item_t it;
    it = start_item($urandom_range(255), $urandom_range(255), $urandom_range(255),
                    $urandom_range(255), $urandom_range(255));
    it.kind = KIND_STEP;
    return it;
  endfunction

  function automatic int near_coord(int c, int span);
    int d, v;
    d = $urandom_range(span);
    v = $urandom_range(1) ? c + d : c - d;
    if (v < 0 || v > 255) v = $urandom_range(255);
    return v;
  endfunction

  task automatic queue_steps(int n);
    repeat (n) pending_items.push_back(step_item());
  endtask

  task automatic queue_lines(int unsigned count);
    int unsigned queued, pick, span, len, steps;
    int x0, y0, x1, y1, adx, ady;
    queued = 0;
    while (queued < count) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        queue_steps(1);
        queued++;
      end else begin
        span = (pick < 12) ? 255 : 12;
        x0 = $urandom_range(255);
        y0 = $urandom_range(255);
        x1 = near_coord(x0, span);
        y1 = near_coord(y0, span);
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;
        len = ((adx > ady) ? adx : ady) + 1;
        pick = $urandom_range(99);
        if (pick < 70) steps = len - 1;
        else if (pick < 85) steps = $urandom_range(len - 1);
        else steps = len - 1 + $urandom_range(1, 3);
        pending_items.push_back(start_item(x0, y0, x1, y1, $urandom_range(255)));
        queue_steps(steps);
        queued += 1 + steps;
      end
    end
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_stride(logic [STRIDE_BITS-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_idling(int unsigned send_pct, int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_steps(1);
    pending_items.push_back(start_item(5, 5, 5, 5, 8'h00));
    queue_steps(1);
    pending_items.push_back(start_item(0, 0, 6, 2, 8'hFF));
    queue_steps(3);
    pending_items.push_back(start_item(200, 100, 197, 110, 8'hA5));
    queue_steps(2);
    pending_items.push_back(start_item(40, 40, 40, 35, 8'h5A));
    queue_steps(6);
    pending_items.push_back(start_item(0, 255, 255, 0, 8'h3C));
    queue_steps(2);
    pending_items.push_back(start_item(255, 0, 0, 255, 8'h81));
    queue_steps(1);
    pending_items.push_back(start_item(9, 9, 12, 12, 8'h42));
    queue_steps(2);
    drain();

    set_stride(8'd1);
    set_idling(47, 0);
    queue_lines(400);
    drain();

    set_stride(8'd255);
    set_idling(0, 47);
    queue_lines(400);
    rx_hold = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    drain();

    set_stride(STRIDE_BITS'($urandom_range(1, 255)));
    set_idling(29, 29);
    queue_lines(400);
    while (pending_items.size() > 200) @(posedge clk);
    send_hold = 1'b1;
    while (in_valid || expected_pixels.size() > 0) @(posedge clk);
    send_hold = 1'b0;
    drain();

    set_stride(ROW_STRIDE_RESET);
    set_idling(0, 0);
    queue_lines(400);
    drain();

    set_stride(STRIDE_BITS'($urandom_range(1, 255)));
    set_idling(29, 29);
    queue_lines(400);
    drain();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
